[sv/rho_discrete_log_walk_assert.svh]
// ----------------------------------------------------------------------------
// rho_discrete_log_walk assertion macros
// Shared property wrappers, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef RHO_DISCRETE_LOG_WALK_ASSERT_SVH
`define RHO_DISCRETE_LOG_WALK_ASSERT_SVH

// same-cycle implication
`define RDLW_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RDLW_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/rdlw_pkg.sv]
// ----------------------------------------------------------------------------
// rdlw_pkg
// Types and constants of the Pollard rho discrete log walk.
// ----------------------------------------------------------------------------
`default_nettype none

package rdlw_pkg;

  localparam int DATA_W       = 32;
  localparam int STEP_W       = 16;
  localparam int CFG_AW       = 4;
  localparam int MOD_BITS_DEF = 32;
  localparam int MOD_MIN      = 3;

  localparam logic [DATA_W-1:0] MODULUS_RST    = 32'd43573;
  localparam logic [DATA_W-1:0] GENERATOR_RST  = 32'd127;
  localparam logic [DATA_W-1:0] TARGET_RST     = 32'd1984;
  localparam logic [STEP_W-1:0] STEP_LIMIT_RST = 16'd100;

  // element residue mod 3 selects the walk move
  localparam logic [1:0] RES_SQUARE = 2'd0;
  localparam logic [1:0] RES_GEN    = 2'd1;
  localparam logic [1:0] RES_TGT    = 2'd2;

  // walk steps within one tick
  localparam logic [1:0] STEP_TORT = 2'd0;
  localparam logic [1:0] STEP_LAST = 2'd2;

  typedef enum logic [1:0] {
    REG_MODULUS,
    REG_GENERATOR,
    REG_TARGET,
    REG_STEP_LIMIT
  } rdlw_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_RX,
    ST_WX,
    ST_RA,
    ST_WA,
    ST_RB,
    ST_WB,
    ST_M3,
    ST_RC,
    ST_WC,
    ST_MUL,
    ST_WM,
    ST_STORE,
    ST_DONE
  } rdlw_state_t;

endpackage

`default_nettype wire

[sv/rdlw_modmul.sv]
// ----------------------------------------------------------------------------
// rdlw_modmul
// Bit-serial modular multiplier: a * b mod m, one bit of b per cycle, MSB
// first. Requires a < m and m >= 2; b may hold any value.
// ----------------------------------------------------------------------------
`default_nettype none

module rdlw_modmul import rdlw_pkg::*; #(
  parameter int W  = MOD_BITS_DEF,
  parameter int XW = DATA_W
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [W-1:0]  a,
  input  wire logic [XW-1:0] b,
  input  wire logic [W-1:0]  m,
  output logic               done,
  output logic [W-1:0]       result
);

  localparam int CW = $clog2(XW + 1);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [W-1:0]  acc_r, acc_nxt;
  logic [W-1:0]  a_r, a_nxt;
  logic [W-1:0]  m_r, m_nxt;
  logic [XW-1:0] b_sr_r, b_sr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [W-1:0]  acc_dbl;
  logic [W-1:0]  acc_step;

  function automatic logic [W-1:0] add_mod(input logic [W-1:0] x, input logic [W-1:0] y,
                                           input logic [W-1:0] md);
    logic [W:0] room;
    logic [W:0] sum;
    room = {1'b0, md} - {1'b0, y};
    sum  = {1'b0, x} + {1'b0, y};
    if ({1'b0, x} >= room) begin
      add_mod = W'({1'b0, x} - room);
    end else begin
      add_mod = W'(sum);
    end
  endfunction

  always_comb begin
    acc_dbl  = add_mod(acc_r, acc_r, m_r);
    acc_step = b_sr_r[XW-1] ? add_mod(acc_dbl, a_r, m_r) : acc_dbl;

    busy_nxt = busy_r;
    done_nxt = busy_r && (cnt_r == CW'(1));
    acc_nxt  = acc_r;
    a_nxt    = a_r;
    m_nxt    = m_r;
    b_sr_nxt = b_sr_r;
    cnt_nxt  = cnt_r;
    if (start) begin
      busy_nxt = 1'b1;
      acc_nxt  = '0;
      a_nxt    = a;
      m_nxt    = m;
      b_sr_nxt = b;
      cnt_nxt  = CW'(XW);
    end else if (busy_r) begin
      acc_nxt  = acc_step;
      b_sr_nxt = b_sr_r << 1;
      cnt_nxt  = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r  <= acc_nxt;
    a_r    <= a_nxt;
    m_r    <= m_nxt;
    b_sr_r <= b_sr_nxt;
    cnt_r  <= cnt_nxt;
  end

  assign done   = done_r;
  assign result = acc_r;

endmodule

`default_nettype wire

[sv/rho_discrete_log_walk.sv]
// ----------------------------------------------------------------------------
// rho_discrete_log_walk
// Pollard rho walk for the discrete logarithm mod a prime: per item the
// tortoise takes one walk step and the hare two per walking item, on a shared serial unit.
// ----------------------------------------------------------------------------
// restart, frozen or limit items pass from ST_IDLE to ST_DONE and into the out regs
// walking items run the walk states for each of three steps, their time set
//   by the bit-serial multiplier and the mod 3 digit pass
// each operand found at or above its modulus adds one reduction pass on the multiplier
// one item at a time; the next is taken while the result waits in out regs
// rst_n (sync) restores register defaults and the walk start state
`default_nettype none

module rho_discrete_log_walk import rdlw_pkg::*; #(
  parameter int MOD_BITS = MOD_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic              in_restart,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [DATA_W-1:0]      out_tortoise_value,
  output logic [DATA_W-1:0]      out_tortoise_gen_exp,
  output logic [DATA_W-1:0]      out_tortoise_tgt_exp,
  output logic [DATA_W-1:0]      out_hare_value,
  output logic [DATA_W-1:0]      out_hare_gen_exp,
  output logic [DATA_W-1:0]      out_hare_tgt_exp,
  output logic [STEP_W-1:0]      out_step_index,
  output logic                   out_collision,
  output logic                   out_limit_hit,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0]      prdata,
  output logic                   pready
);

  localparam int W    = MOD_BITS;
  localparam int XW   = (MOD_BITS > DATA_W) ? MOD_BITS : DATA_W;
  localparam int NDIG = (MOD_BITS + 3) / 4;
  localparam int M3W  = 4 * NDIG;
  localparam int M3CW = $clog2(NDIG + 1);

  // configuration
  logic [DATA_W-1:0] modulus_r, generator_r, target_r;
  logic [STEP_W-1:0] step_limit_r;
  rdlw_reg_t         reg_sel;
  logic              cfg_we;

  // walk state
  rdlw_state_t       state_r, state_nxt;
  logic [W-1:0]      tort_elem_r, tort_elem_nxt, tort_ea_r, tort_ea_nxt, tort_eb_r, tort_eb_nxt;
  logic [W-1:0]      hare_elem_r, hare_elem_nxt, hare_ea_r, hare_ea_nxt, hare_eb_r, hare_eb_nxt;
  logic [STEP_W-1:0] tick_r, tick_nxt;
  logic              stopped_r, stopped_nxt;
  logic [1:0]        step_cnt_r, step_cnt_nxt;

  // working registers
  logic [W-1:0]      e_r, e_nxt, ea_r, ea_nxt, eb_r, eb_nxt, c_r, c_nxt;
  logic [1:0]        res_r, res_nxt;
  logic [M3W-1:0]    m3_sr_r, m3_sr_nxt;
  logic [M3CW-1:0]   m3_cnt_r, m3_cnt_nxt;

  // result registers
  logic              out_valid_r, out_valid_nxt;
  logic [W-1:0]      o_tv_r, o_tv_nxt, o_ta_r, o_ta_nxt, o_tb_r, o_tb_nxt;
  logic [W-1:0]      o_hv_r, o_hv_nxt, o_ha_r, o_ha_nxt, o_hb_r, o_hb_nxt;
  logic [STEP_W-1:0] o_step_r, o_step_nxt;
  logic              o_coll_r, o_coll_nxt, o_lim_r, o_lim_nxt;

  // moduli
  logic [XW-1:0]     mod_x;
  logic [W-1:0]      p_raw, p_eff, n_eff;
  logic [XW-1:0]     c_sel;
  logic              coll_now;

  // shared multiplier
  logic              mm_start, mm_done;
  logic [W-1:0]      mm_a, mm_m, mm_result;
  logic [XW-1:0]     mm_b;

  function automatic logic [W-1:0] add_mod(input logic [W-1:0] x, input logic [W-1:0] y,
                                           input logic [W-1:0] md);
    logic [W:0] room;
    logic [W:0] sum;
    room = {1'b0, md} - {1'b0, y};
    sum  = {1'b0, x} + {1'b0, y};
    if ({1'b0, x} >= room) begin
      add_mod = W'({1'b0, x} - room);
    end else begin
      add_mod = W'(sum);
    end
  endfunction

  function automatic logic [W-1:0] inc_mod(input logic [W-1:0] x, input logic [W-1:0] md);
    logic [W-1:0] s;
    s = x + W'(1);
    inc_mod = (s == md) ? '0 : s;
  endfunction

  // 16 is 1 mod 3, so hex digits just add up
  function automatic logic [1:0] mod3_fold(input logic [1:0] t, input logic [3:0] d);
    logic [4:0] v;
    v = 5'(t) + 5'(d);
    if (v >= 5'd12) v = v - 5'd12;
    if (v >= 5'd6)  v = v - 5'd6;
    if (v >= 5'd3)  v = v - 5'd3;
    mod3_fold = v[1:0];
  endfunction

  rdlw_modmul #(
    .W  (W),
    .XW (XW)
  ) u_modmul (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mm_start),
    .a      (mm_a),
    .b      (mm_b),
    .m      (mm_m),
    .done   (mm_done),
    .result (mm_result)
  );

  // configuration port
  assign reg_sel = rdlw_reg_t'(paddr[CFG_AW-1:2]);
  assign cfg_we  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r    <= MODULUS_RST;
      generator_r  <= GENERATOR_RST;
      target_r     <= TARGET_RST;
      step_limit_r <= STEP_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (reg_sel)
        REG_MODULUS:    modulus_r    <= pwdata;
        REG_GENERATOR:  generator_r  <= pwdata;
        REG_TARGET:     target_r     <= pwdata;
        REG_STEP_LIMIT: step_limit_r <= pwdata[STEP_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_MODULUS:    prdata = modulus_r;
      REG_GENERATOR:  prdata = generator_r;
      REG_TARGET:     prdata = target_r;
      REG_STEP_LIMIT: prdata = DATA_W'(step_limit_r);
    endcase
  end

  // effective moduli, small modulus clamped to 3
  always_comb begin
    mod_x = XW'(modulus_r);
    p_raw = mod_x[W-1:0];
    p_eff = (p_raw < W'(MOD_MIN)) ? W'(MOD_MIN) : p_raw;
    n_eff = p_eff - W'(1);
  end

  always_comb begin
    case (res_r)
      RES_SQUARE: c_sel = XW'(e_r);
      RES_GEN:    c_sel = XW'(generator_r);
      RES_TGT:    c_sel = XW'(target_r);
      default:    c_sel = XW'(e_r);
    endcase
  end

  assign coll_now = (tick_r != '0) && (tort_elem_r == hare_elem_r);
  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    state_nxt     = state_r;
    tort_elem_nxt = tort_elem_r;
    tort_ea_nxt   = tort_ea_r;
    tort_eb_nxt   = tort_eb_r;
    hare_elem_nxt = hare_elem_r;
    hare_ea_nxt   = hare_ea_r;
    hare_eb_nxt   = hare_eb_r;
    tick_nxt      = tick_r;
    stopped_nxt   = stopped_r;
    step_cnt_nxt  = step_cnt_r;
    e_nxt         = e_r;
    ea_nxt        = ea_r;
    eb_nxt        = eb_r;
    c_nxt         = c_r;
    res_nxt       = res_r;
    m3_sr_nxt     = m3_sr_r;
    m3_cnt_nxt    = m3_cnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    o_tv_nxt      = o_tv_r;
    o_ta_nxt      = o_ta_r;
    o_tb_nxt      = o_tb_r;
    o_hv_nxt      = o_hv_r;
    o_ha_nxt      = o_ha_r;
    o_hb_nxt      = o_hb_r;
    o_step_nxt    = o_step_r;
    o_coll_nxt    = o_coll_r;
    o_lim_nxt     = o_lim_r;
    mm_start      = 1'b0;
    mm_a          = W'(1);
    mm_b          = XW'(e_r);
    mm_m          = p_eff;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          step_cnt_nxt = STEP_TORT;
          if (in_restart) begin
            tort_elem_nxt = W'(1);
            tort_ea_nxt   = '0;
            tort_eb_nxt   = '0;
            hare_elem_nxt = W'(1);
            hare_ea_nxt   = '0;
            hare_eb_nxt   = '0;
            tick_nxt      = '0;
            stopped_nxt   = 1'b0;
            state_nxt     = ST_DONE;
          end else if (stopped_r) begin
            state_nxt = ST_DONE;
          end else if (tick_r >= step_limit_r) begin
            stopped_nxt = 1'b1;
            state_nxt   = ST_DONE;
          end else begin
            state_nxt = ST_LOAD;
          end
        end
      end
      ST_LOAD: begin
        if (step_cnt_r == STEP_TORT) begin
          e_nxt  = tort_elem_r;
          ea_nxt = tort_ea_r;
          eb_nxt = tort_eb_r;
        end else begin
          e_nxt  = hare_elem_r;
          ea_nxt = hare_ea_r;
          eb_nxt = hare_eb_r;
        end
        state_nxt = ST_RX;
      end
      ST_RX: begin
        if (e_r >= p_eff) begin
          mm_start  = 1'b1;
          state_nxt = ST_WX;
        end else begin
          state_nxt = ST_RA;
        end
      end
      ST_WX: begin
        if (mm_done) begin
          e_nxt     = mm_result;
          state_nxt = ST_RA;
        end
      end
      ST_RA: begin
        m3_sr_nxt  = M3W'(e_r);
        m3_cnt_nxt = M3CW'(NDIG);
        res_nxt    = RES_SQUARE;
        if (ea_r >= n_eff) begin
          mm_start  = 1'b1;
          mm_b      = XW'(ea_r);
          mm_m      = n_eff;
          state_nxt = ST_WA;
        end else begin
          state_nxt = ST_RB;
        end
      end
      ST_WA: begin
        if (mm_done) begin
          ea_nxt    = mm_result;
          state_nxt = ST_RB;
        end
      end
      ST_RB: begin
        if (eb_r >= n_eff) begin
          mm_start  = 1'b1;
          mm_b      = XW'(eb_r);
          mm_m      = n_eff;
          state_nxt = ST_WB;
        end else begin
          state_nxt = ST_M3;
        end
      end
      ST_WB: begin
        if (mm_done) begin
          eb_nxt    = mm_result;
          state_nxt = ST_M3;
        end
      end
      ST_M3: begin
        res_nxt    = mod3_fold(res_r, m3_sr_r[3:0]);
        m3_sr_nxt  = m3_sr_r >> 4;
        m3_cnt_nxt = m3_cnt_r - M3CW'(1);
        if (m3_cnt_r == M3CW'(1)) begin
          state_nxt = ST_RC;
        end
      end
      ST_RC: begin
        if (c_sel >= XW'(p_eff)) begin
          mm_start  = 1'b1;
          mm_b      = c_sel;
          state_nxt = ST_WC;
        end else begin
          c_nxt     = c_sel[W-1:0];
          state_nxt = ST_MUL;
        end
      end
      ST_WC: begin
        if (mm_done) begin
          c_nxt     = mm_result;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        mm_start = 1'b1;
        mm_a     = e_r;
        mm_b     = XW'(c_r);
        case (res_r)
          RES_TGT: eb_nxt = inc_mod(eb_r, n_eff);
          RES_GEN: ea_nxt = inc_mod(ea_r, n_eff);
          RES_SQUARE: begin
            ea_nxt = add_mod(ea_r, ea_r, n_eff);
            eb_nxt = add_mod(eb_r, eb_r, n_eff);
          end
          default: ;
        endcase
        state_nxt = ST_WM;
      end
      ST_WM: begin
        if (mm_done) begin
          e_nxt     = mm_result;
          state_nxt = ST_STORE;
        end
      end
      ST_STORE: begin
        if (step_cnt_r == STEP_TORT) begin
          tort_elem_nxt = e_r;
          tort_ea_nxt   = ea_r;
          tort_eb_nxt   = eb_r;
        end else begin
          hare_elem_nxt = e_r;
          hare_ea_nxt   = ea_r;
          hare_eb_nxt   = eb_r;
        end
        if (step_cnt_r == STEP_LAST) begin
          tick_nxt = tick_r + STEP_W'(1);
          if ((tort_elem_r == e_r) || (tick_nxt >= step_limit_r)) begin
            stopped_nxt = 1'b1;
          end
          state_nxt = ST_DONE;
        end else begin
          step_cnt_nxt = step_cnt_r + 2'd1;
          state_nxt    = ST_LOAD;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          o_tv_nxt      = tort_elem_r;
          o_ta_nxt      = tort_ea_r;
          o_tb_nxt      = tort_eb_r;
          o_hv_nxt      = hare_elem_r;
          o_ha_nxt      = hare_ea_r;
          o_hb_nxt      = hare_eb_r;
          o_step_nxt    = tick_r;
          o_coll_nxt    = coll_now;
          o_lim_nxt     = stopped_r && !coll_now;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      step_cnt_r  <= STEP_TORT;
      tort_elem_r <= W'(1);
      tort_ea_r   <= '0;
      tort_eb_r   <= '0;
      hare_elem_r <= W'(1);
      hare_ea_r   <= '0;
      hare_eb_r   <= '0;
      tick_r      <= '0;
      stopped_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      step_cnt_r  <= step_cnt_nxt;
      tort_elem_r <= tort_elem_nxt;
      tort_ea_r   <= tort_ea_nxt;
      tort_eb_r   <= tort_eb_nxt;
      hare_elem_r <= hare_elem_nxt;
      hare_ea_r   <= hare_ea_nxt;
      hare_eb_r   <= hare_eb_nxt;
      tick_r      <= tick_nxt;
      stopped_r   <= stopped_nxt;
    end
  end

  always_ff @(posedge clk) begin
    e_r      <= e_nxt;
    ea_r     <= ea_nxt;
    eb_r     <= eb_nxt;
    c_r      <= c_nxt;
    res_r    <= res_nxt;
    m3_sr_r  <= m3_sr_nxt;
    m3_cnt_r <= m3_cnt_nxt;
    o_tv_r   <= o_tv_nxt;
    o_ta_r   <= o_ta_nxt;
    o_tb_r   <= o_tb_nxt;
    o_hv_r   <= o_hv_nxt;
    o_ha_r   <= o_ha_nxt;
    o_hb_r   <= o_hb_nxt;
    o_step_r <= o_step_nxt;
    o_coll_r <= o_coll_nxt;
    o_lim_r  <= o_lim_nxt;
  end

  assign out_valid            = out_valid_r;
  assign out_tortoise_value   = DATA_W'(o_tv_r);
  assign out_tortoise_gen_exp = DATA_W'(o_ta_r);
  assign out_tortoise_tgt_exp = DATA_W'(o_tb_r);
  assign out_hare_value       = DATA_W'(o_hv_r);
  assign out_hare_gen_exp     = DATA_W'(o_ha_r);
  assign out_hare_tgt_exp     = DATA_W'(o_hb_r);
  assign out_step_index       = o_step_r;
  assign out_collision        = o_coll_r;
  assign out_limit_hit        = o_lim_r;

endmodule

`default_nettype wire

[sv/rdlw_checker.sv]
// ----------------------------------------------------------------------------
// rdlw_checker
// Port-level checks of the rho walk, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "rho_discrete_log_walk_assert.svh"

module rdlw_checker import rdlw_pkg::*; (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_stall,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire logic [DATA_W-1:0] out_tortoise_value,
  input wire logic [DATA_W-1:0] out_hare_value,
  input wire logic [STEP_W-1:0] out_step_index,
  input wire logic              out_collision
);

  `RDLW_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_tortoise_value) && $stable(out_step_index), "stalled result item changed")

  `RDLW_ASSERT_NXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "input not stalled after an accepted item")

  `RDLW_ASSERT_IMP(a_coll_equal, out_valid && out_collision, out_tortoise_value == out_hare_value, "collision flagged on unequal elements")

  `RDLW_ASSERT_IMP(a_start_point, out_valid && (out_step_index == 16'd0), (out_tortoise_value == 32'd1) && (out_hare_value == 32'd1) && !out_collision, "walk left element one without a tick")

endmodule

bind rho_discrete_log_walk rdlw_checker u_rdlw_checker (.*);

`default_nettype wire

[dv/tb_rho_discrete_log_walk.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rho_discrete_log_walk
// Self-checking bench for the Pollard rho walk. Restart and tick items go in
// under random idling on both channels. An in-bench model of tortoise and hare
// predicts every result, and each one is compared field by field. APB writes
// move the walk through small, wide and degenerate moduli and step limits.
// ----------------------------------------------------------------------------
module tb_rho_discrete_log_walk;
  import rdlw_pkg::*;

  localparam int MAX_CYCLES  = 5_000_000;
  localparam int TAIL_CYCLES = 600;

  typedef struct packed {
    logic [DATA_W-1:0] tort_val;
    logic [DATA_W-1:0] tort_gexp;
    logic [DATA_W-1:0] tort_texp;
    logic [DATA_W-1:0] hare_val;
    logic [DATA_W-1:0] hare_gexp;
    logic [DATA_W-1:0] hare_texp;
    logic [STEP_W-1:0] steps;
    logic              coll;
    logic              limit;
  } walk_out_t;

  logic              clk;
  logic              rst_n      = 1'b0;
  logic              in_valid   = 1'b0;
  logic              in_restart = 1'b0;
  logic              out_stall  = 1'b0;
  logic              psel       = 1'b0;
  logic              penable    = 1'b0;
  logic              pwrite     = 1'b0;
  logic [CFG_AW-1:0] paddr      = '0;
  logic [DATA_W-1:0] pwdata     = '0;

  logic              in_stall;
  logic              out_valid;
  logic [DATA_W-1:0] out_tortoise_value;
  logic [DATA_W-1:0] out_tortoise_gen_exp;
  logic [DATA_W-1:0] out_tortoise_tgt_exp;
  logic [DATA_W-1:0] out_hare_value;
  logic [DATA_W-1:0] out_hare_gen_exp;
  logic [DATA_W-1:0] out_hare_tgt_exp;
  logic [STEP_W-1:0] out_step_index;
  logic              out_collision;
  logic              out_limit_hit;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  rho_discrete_log_walk dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_restart           (in_restart),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_tortoise_value   (out_tortoise_value),
    .out_tortoise_gen_exp (out_tortoise_gen_exp),
    .out_tortoise_tgt_exp (out_tortoise_tgt_exp),
    .out_hare_value       (out_hare_value),
    .out_hare_gen_exp     (out_hare_gen_exp),
    .out_hare_tgt_exp     (out_hare_tgt_exp),
    .out_step_index       (out_step_index),
    .out_collision        (out_collision),
    .out_limit_hit        (out_limit_hit),
    .psel                 (psel),
    .penable              (penable),
    .pwrite               (pwrite),
    .paddr                (paddr),
    .pwdata               (pwdata),
    .prdata               (prdata),
    .pready               (pready)
  );

  // walk model state and register shadows
  logic [DATA_W-1:0] cfg_mod, cfg_gen, cfg_tgt;
  logic [STEP_W-1:0] cfg_limit;
  logic [63:0]       tort_x, tort_g, tort_t;
  logic [63:0]       hare_x, hare_g, hare_t;
  logic [STEP_W-1:0] walk_ticks;
  logic              walk_frozen;
  walk_out_t         expected_q[$];

  bit  gaps_on  = 1'b1;
  bit  stall_on = 1'b1;
  int  stall_left = 0;
  int  cycles = 0;
  int  errors = 0;
  int  items_sent = 0;
  int  walking_ticks = 0;
  int  cfg_writes = 0;
  int  results_seen = 0;
  int  collisions_seen = 0;
  int  limits_seen = 0;
  walk_out_t seen_out, want_out;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) cycles <= cycles + 1;

  initial begin
    while (cycles < MAX_CYCLES) @(posedge clk);
    $display("tb: failure");
    $finish;
  end

  // ---- walk model --------------------------------------------------------

  function automatic void restart_walk();
    tort_x = 64'd1;
    tort_g = '0;
    tort_t = '0;
    hare_x = 64'd1;
    hare_g = '0;
    hare_t = '0;
    walk_ticks  = '0;
    walk_frozen = 1'b0;
  endfunction

  function automatic void walk_move(inout logic [63:0] x, gexp, texp,
                                    input logic [63:0] p);
    logic [63:0] n, e, a, b;
    n = p - 64'd1;
    e = x % p;
    a = gexp % n;
    b = texp % n;
    case (2'(e % 64'd3))
      RES_TGT: begin
        e = (e * (64'(cfg_tgt) % p)) % p;
        b = (b + 64'd1 == n) ? 64'd0 : b + 64'd1;
      end
      RES_GEN: begin
        e = (e * (64'(cfg_gen) % p)) % p;
        a = (a + 64'd1 == n) ? 64'd0 : a + 64'd1;
      end
      default: begin
        e = (e * e) % p;
        a = (a + a) % n;
        b = (b + b) % n;
      end
    endcase
    x    = e;
    gexp = a;
    texp = b;
  endfunction

  function automatic walk_out_t predict_tick(logic restart);
    walk_out_t   r;
    logic [63:0] p;
    logic        meet;
    if (restart) begin
      restart_walk();
    end else if (!walk_frozen) begin
      if (walk_ticks >= cfg_limit) begin
        walk_frozen = 1'b1;
      end else begin
        p = (cfg_mod < MOD_MIN) ? 64'(MOD_MIN) : 64'(cfg_mod);
        walk_move(tort_x, tort_g, tort_t, p);
        walk_move(hare_x, hare_g, hare_t, p);
        walk_move(hare_x, hare_g, hare_t, p);
        walk_ticks = walk_ticks + 1'b1;
        walking_ticks++;
        if (tort_x == hare_x || walk_ticks >= cfg_limit) walk_frozen = 1'b1;
      end
    end
    meet = (walk_ticks != 0) && (tort_x == hare_x);
    r.tort_val  = tort_x[DATA_W-1:0];
    r.tort_gexp = tort_g[DATA_W-1:0];
    r.tort_texp = tort_t[DATA_W-1:0];
    r.hare_val  = hare_x[DATA_W-1:0];
    r.hare_gexp = hare_g[DATA_W-1:0];
    r.hare_texp = hare_t[DATA_W-1:0];
    r.steps     = walk_ticks;
    r.coll      = meet;
    r.limit     = walk_frozen && !meet;
    return r;
  endfunction

  // ---- result side ---------------------------------------------------------

  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (stall_on && $urandom_range(0, 5) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 6);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      seen_out = {out_tortoise_value, out_tortoise_gen_exp, out_tortoise_tgt_exp,
                  out_hare_value, out_hare_gen_exp, out_hare_tgt_exp,
                  out_step_index, out_collision, out_limit_hit};
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("%0t: result with no item pending", $time);
      end else begin
        want_out = expected_q.pop_front();
        results_seen++;
        if (want_out.coll) collisions_seen++;
        if (want_out.limit) limits_seen++;
        if (seen_out !== want_out) begin
          errors++;
          if (errors <= 10) begin
            $display("%0t: mismatch on result %0d", $time, results_seen);
            $display("  exp tort %h %h %h hare %h %h %h step %0d coll %b lim %b",
                     want_out.tort_val, want_out.tort_gexp, want_out.tort_texp,
                     want_out.hare_val, want_out.hare_gexp, want_out.hare_texp,
                     want_out.steps, want_out.coll, want_out.limit);
            $display("  got tort %h %h %h hare %h %h %h step %0d coll %b lim %b",
                     seen_out.tort_val, seen_out.tort_gexp, seen_out.tort_texp,
                     seen_out.hare_val, seen_out.hare_gexp, seen_out.hare_texp,
                     seen_out.steps, seen_out.coll, seen_out.limit);
          end
        end
      end
    end
  end

  // ---- stimulus helpers ----------------------------------------------------

  task automatic send_item(logic restart);
    in_valid   <= 1'b1;
    in_restart <= restart;
    do @(posedge clk); while (in_stall);
    expected_q.push_back(predict_tick(restart));
    items_sent++;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid   <= 1'b0;
      in_restart <= 1'($urandom);
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
  endtask

  task automatic run_walk(int ticks);
    send_item(1'b1);
    repeat (ticks) send_item(1'b0);
  endtask

  task automatic wait_results();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic cfg_write(rdlw_reg_t idx, logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_AW'({idx, 2'b00});
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_MODULUS:    cfg_mod   = value;
      REG_GENERATOR:  cfg_gen   = value;
      REG_TARGET:     cfg_tgt   = value;
      REG_STEP_LIMIT: cfg_limit = value[STEP_W-1:0];
      default: ;
    endcase
    cfg_writes++;
    @(posedge clk);
  endtask

  task automatic set_config(logic [DATA_W-1:0] m, g, t, logic [STEP_W-1:0] l);
    wait_results();
    cfg_write(REG_MODULUS, m);
    cfg_write(REG_GENERATOR, g);
    cfg_write(REG_TARGET, t);
    cfg_write(REG_STEP_LIMIT, {16'($urandom), l});
  endtask

  // ---- tests ---------------------------------------------------------------

  task automatic test_defaults();
    send_item(1'b0);
    send_item(1'b0);
    send_item(1'b1);
    send_item(1'b0);
  endtask

  task automatic test_limit_zero();
    wait_results();
    cfg_write(REG_STEP_LIMIT, 32'd0);
    send_item(1'b1);
    send_item(1'b0);
    send_item(1'b0);
  endtask

  // modulus below three, unreduced generator, zero target
  task automatic test_small_modulus();
    set_config(32'd0, 32'hFFFF_FFFF, 32'd0, 16'd6);
    run_walk(4);
  endtask

  task automatic test_wide_operands();
    set_config(32'hFFFF_FFFB, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 16'hFFFF);
    run_walk(3);
  endtask

  // shrink the modulus mid walk so state and exponents need reducing
  task automatic test_unreduced_state();
    wait_results();
    cfg_write(REG_MODULUS, 32'd7);
    send_item(1'b0);
    send_item(1'b0);
  endtask

  task automatic test_collision();
    set_config(32'd11, 32'd2, 32'd7, 16'd200);
    run_walk(7);
  endtask

  task automatic pick_config();
    logic [DATA_W-1:0] m, g, t, top;
    logic [STEP_W-1:0] l;
    case ($urandom_range(0, 8))
      0: m = $urandom_range(0, 2);
      1: m = 32'hFFFF_FFFB;
      2: m = 32'hFFFF_FFFF;
      3: m = $urandom;
      4: m = 32'd5;
      5: m = 32'd11;
      6: m = 32'd101;
      7: m = 32'd43573;
      default: m = 32'd65521;
    endcase
    top = (m < MOD_MIN) ? 32'(MOD_MIN - 1) : m - 32'd1;
    case ($urandom_range(0, 5))
      0: g = '0;
      1: g = 32'hFFFF_FFFF;
      2: g = $urandom;
      default: g = $urandom_range(0, top);
    endcase
    case ($urandom_range(0, 5))
      0: t = '0;
      1: t = 32'hFFFF_FFFF;
      2: t = $urandom;
      default: t = $urandom_range(0, top);
    endcase
    case ($urandom_range(0, 7))
      0: l = '0;
      1: l = 16'hFFFF;
      2: l = $urandom_range(41, 400);
      default: l = $urandom_range(1, 40);
    endcase
    set_config(m, g, t, l);
  endtask

  task automatic test_random_walks();
    int quota, span;
    quota = items_sent + 1040;
    while (items_sent < quota) begin
      stall_on = $urandom_range(0, 3) != 0;
      pick_config();
      repeat ($urandom_range(3, 8)) begin
        gaps_on = $urandom_range(0, 3) != 0;
        span = (cfg_limit < 60) ? int'(cfg_limit) : 60;
        case ($urandom_range(0, 9))
          0: repeat ($urandom_range(1, 12)) send_item(1'($urandom));
          1: begin
            run_walk($urandom_range(1, span + 3));
            wait_results();
          end
          default: run_walk($urandom_range(1, span + 3));
        endcase
      end
    end
  endtask

  task automatic test_back_to_back();
    gaps_on  = 1'b0;
    stall_on = 1'b0;
    set_config(32'd43573, 32'd127, 32'd1984, 16'd45);
    run_walk(48);
    repeat (6) send_item(1'($urandom));
    run_walk(40);
  endtask

  initial begin
    cfg_mod   = MODULUS_RST;
    cfg_gen   = GENERATOR_RST;
    cfg_tgt   = TARGET_RST;
    cfg_limit = STEP_LIMIT_RST;
    restart_walk();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_defaults();
    test_limit_zero();
    test_small_modulus();
    test_wide_operands();
    test_unreduced_state();
    test_collision();
    test_random_walks();
    test_back_to_back();

    wait_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("summary: %0d items sent, %0d walking ticks, %0d register writes, %0d cycles",
             items_sent, walking_ticks, cfg_writes, cycles);
    $display("summary: %0d results checked, %0d collisions, %0d limit stops, %0d errors",
             results_seen, collisions_seen, limits_seen, errors);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+sv
sv/rdlw_pkg.sv
sv/rdlw_modmul.sv
sv/rho_discrete_log_walk.sv
sv/rdlw_checker.sv
dv/tb_rho_discrete_log_walk.sv
